// File: design/xsid_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helper functions for the x86 subset decoder.
// No dependencies; used by xsid_step, the top level and the checker.

package xsid_pkg;

  // Parse phase codes
  localparam logic [2:0] PH_PREFIX  = 3'd0;
  localparam logic [2:0] PH_OPCODE  = 3'd1;
  localparam logic [2:0] PH_MODRM   = 3'd2;
  localparam logic [2:0] PH_OPC2    = 3'd3;
  localparam logic [2:0] PH_SSESKIP = 3'd4;
  localparam logic [2:0] PH_IMM     = 3'd5;

  localparam logic [4:0] REG_NONE = 5'd16;

  // Operation kinds
  localparam logic [5:0] K_UNKNOWN  = 6'd0;
  localparam logic [5:0] K_MOV_RR   = 6'd1;
  localparam logic [5:0] K_MOV_RI   = 6'd2;
  localparam logic [5:0] K_MOV_RM   = 6'd3;
  localparam logic [5:0] K_MOV_MR   = 6'd4;
  localparam logic [5:0] K_PUSH     = 6'd5;
  localparam logic [5:0] K_POP      = 6'd6;
  localparam logic [5:0] K_LEA      = 6'd7;
  localparam logic [5:0] K_ADD_RR   = 6'd8;
  localparam logic [5:0] K_ADD_RI   = 6'd9;
  localparam logic [5:0] K_SUB_RR   = 6'd10;
  localparam logic [5:0] K_SUB_RI   = 6'd11;
  localparam logic [5:0] K_AND_RI   = 6'd20;
  localparam logic [5:0] K_OR_RI    = 6'd22;
  localparam logic [5:0] K_XOR_RR   = 6'd23;
  localparam logic [5:0] K_XOR_RI   = 6'd24;
  localparam logic [5:0] K_CMP_RR   = 6'd29;
  localparam logic [5:0] K_CMP_RI   = 6'd30;
  localparam logic [5:0] K_TEST_RR  = 6'd31;
  localparam logic [5:0] K_JMP_REL  = 6'd33;
  localparam logic [5:0] K_JCC      = 6'd35;
  localparam logic [5:0] K_CALL_REL = 6'd36;
  localparam logic [5:0] K_RET      = 6'd38;
  localparam logic [5:0] K_MOVAPS   = 6'd39;
  localparam logic [5:0] K_MOVUPS   = 6'd40;
  localparam logic [5:0] K_ADDPS    = 6'd41;
  localparam logic [5:0] K_MULPS    = 6'd43;
  localparam logic [5:0] K_SYSCALL  = 6'd45;
  localparam logic [5:0] K_NOP      = 6'd46;
  localparam logic [5:0] K_INT3     = 6'd47;

  // Prefix bytes
  localparam logic [7:0] PFX_LOCK  = 8'hF0;
  localparam logic [7:0] PFX_REPNE = 8'hF2;
  localparam logic [7:0] PFX_REP   = 8'hF3;
  localparam logic [7:0] PFX_OPSZ  = 8'h66;
  localparam logic [7:0] PFX_ADSZ  = 8'h67;
  localparam logic [7:0] PFX_CS    = 8'h2E;
  localparam logic [7:0] PFX_DS    = 8'h3E;
  localparam logic [7:0] PFX_ES    = 8'h26;
  localparam logic [7:0] PFX_FS    = 8'h64;
  localparam logic [7:0] PFX_GS    = 8'h65;
  localparam logic [7:0] PFX_SS    = 8'h36;
  localparam logic [3:0] REX_HI    = 4'h4;

  // One-byte opcodes
  localparam logic [7:0] OP_PUSH      = 8'h50;
  localparam logic [7:0] OP_POP       = 8'h58;
  localparam logic [7:0] OP_MOV_IMM   = 8'hB8;
  localparam logic [7:0] OP_JCC8      = 8'h70;
  localparam logic [7:0] OP_ESC       = 8'h0F;
  localparam logic [7:0] OP_GRP83     = 8'h83;
  localparam logic [7:0] OP_NOP       = 8'h90;
  localparam logic [7:0] OP_RET       = 8'hC3;
  localparam logic [7:0] OP_INT3      = 8'hCC;
  localparam logic [7:0] OP_MOV_LOAD  = 8'h8B;
  localparam logic [7:0] OP_MOV_STORE = 8'h89;
  localparam logic [7:0] OP_ADD       = 8'h03;
  localparam logic [7:0] OP_SUB       = 8'h2B;
  localparam logic [7:0] OP_XOR       = 8'h33;
  localparam logic [7:0] OP_CMP       = 8'h3B;
  localparam logic [7:0] OP_TEST      = 8'h85;
  localparam logic [7:0] OP_LEA       = 8'h8D;
  localparam logic [7:0] OP_JMP8      = 8'hEB;
  localparam logic [7:0] OP_JMP32     = 8'hE9;
  localparam logic [7:0] OP_CALL      = 8'hE8;

  // Second opcode bytes after 0F
  localparam logic [7:0] OP2_JCC32   = 8'h80;
  localparam logic [7:0] OP2_SYSCALL = 8'h05;
  localparam logic [7:0] OP2_MOVAPS  = 8'h28;
  localparam logic [7:0] OP2_MOVUPS  = 8'h10;
  localparam logic [7:0] OP2_ADDPS   = 8'h58;
  localparam logic [7:0] OP2_MULPS   = 8'h59;

  typedef struct packed {
    logic [5:0] kind;
    logic [4:0] dst;
    logic [4:0] src;
    logic [3:0] cond;
    logic       flags;
  } rec_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [7:0]  count;
    logic [3:0]  rex;     // W,R,X,B
    logic [1:0]  pfx;     // bit1 rep, bit0 lock
    logic [7:0]  opcode;
    rec_t        rec;
    logic [63:0] acc;
    logic [3:0]  got;
    logic [3:0]  want;
  } st_t;

  typedef struct packed {
    logic        emit;
    logic        ok;
    logic [5:0]  kind;
    logic [4:0]  dst;
    logic [4:0]  src;
    logic [3:0]  cond;
    logic [63:0] imm;
    logic        lock;
    logic        rep;
    logic        wide;
    logic        flags;
    logic [7:0]  len;
  } res_t;

  // State at the start of every instruction
  function automatic st_t st_clear();
    st_t s;
    s.phase      = PH_PREFIX;
    s.count      = 8'd0;
    s.rex        = 4'd0;
    s.pfx        = 2'd0;
    s.opcode     = 8'd0;
    s.rec.kind   = K_UNKNOWN;
    s.rec.dst    = REG_NONE;
    s.rec.src    = REG_NONE;
    s.rec.cond   = 4'd0;
    s.rec.flags  = 1'b0;
    s.acc        = 64'd0;
    s.got        = 4'd0;
    s.want       = 4'd0;
    return s;
  endfunction

  // 0x83 group operation from ModRM.reg (no REX.R)
  function automatic logic [5:0] grp83_kind(input logic [2:0] reg3);
    logic [5:0] k;
    case (reg3)
      3'd0:    k = K_ADD_RI;
      3'd1:    k = K_OR_RI;
      3'd4:    k = K_AND_RI;
      3'd5:    k = K_SUB_RI;
      3'd6:    k = K_XOR_RI;
      3'd7:    k = K_CMP_RI;
      default: k = K_UNKNOWN;
    endcase
    return k;
  endfunction

  // Sign extension by immediate size in bytes (1 and 4 extend, else raw)
  function automatic logic [63:0] sext_imm(input logic [63:0] v, input logic [3:0] nbytes);
    logic [63:0] r;
    case (nbytes)
      4'd1:    r = {{56{v[7]}}, v[7:0]};
      4'd4:    r = {{32{v[31]}}, v[31:0]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

// File: design/xsid_step.sv
`timescale 1ns / 1ps
// Per-byte parse step: next parse state and the decoded record for one code byte.
// Purely combinational; depends on xsid_pkg.

module xsid_step (
  input  xsid_pkg::st_t  st,
  input  logic [7:0]     code_byte,
  input  logic           end_of_code,
  output xsid_pkg::st_t  st_nxt,
  output xsid_pkg::res_t res
);

  xsid_pkg::st_t w;
  logic        opc_go;
  logic        imm_go;
  logic [3:0]  imm_want;
  logic        emit;
  logic        ok;
  logic [63:0] imm;
  logic [3:0]  extra;
  logic [7:0]  cnt_inc;
  logic [1:0]  modrm_mod;
  logic [2:0]  modrm_reg;
  logic [4:0]  reg_full;
  logic [4:0]  rm_full;
  logic [63:0] acc_w;
  logic [3:0]  got_n;
  logic [8:0]  len_sum;
  logic [7:0]  len_sat;

  // Byte count saturates at 255
  assign cnt_inc   = (st.count == 8'hFF) ? 8'hFF : st.count + 8'd1;
  assign modrm_mod = code_byte[7:6];
  assign modrm_reg = code_byte[5:3];
  assign reg_full  = {1'b0, st.rex[2], code_byte[5:3]};
  assign rm_full   = {1'b0, st.rex[0], code_byte[2:0]};

  // Immediate byte lands in the lane selected by the immediate bytes already received, little endian
  assign acc_w = st.acc | ({56'd0, code_byte} << {st.got[2:0], 3'b000});
  assign got_n = {1'b0, st.got[2:0]} + 4'd1;

  always_comb begin
    w        = st;
    opc_go   = 1'b0;
    imm_go   = 1'b0;
    imm_want = 4'd0;
    emit     = 1'b0;
    ok       = 1'b1;
    imm      = 64'd0;
    extra    = 4'd0;

    // Phase dispatch
    case (st.phase)
      xsid_pkg::PH_OPCODE: begin
        opc_go = 1'b1;
      end
      xsid_pkg::PH_MODRM: begin
        w.count = cnt_inc;
        emit    = 1'b1;
        case (st.opcode)
          xsid_pkg::OP_GRP83: begin
            emit        = 1'b0;
            w.rec.flags = 1'b1;
            w.rec.kind  = xsid_pkg::grp83_kind(modrm_reg);
            if (modrm_mod == 2'd3) begin
              w.rec.dst = rm_full;
            end
            imm_go   = 1'b1;
            imm_want = 4'd1;
          end
          xsid_pkg::OP_MOV_LOAD: begin
            w.rec.dst = reg_full;
            if (modrm_mod == 2'd3) begin
              w.rec.kind = xsid_pkg::K_MOV_RR;
              w.rec.src  = rm_full;
            end else begin
              w.rec.kind = xsid_pkg::K_MOV_RM;
            end
          end
          xsid_pkg::OP_MOV_STORE: begin
            w.rec.src = reg_full;
            if (modrm_mod == 2'd3) begin
              w.rec.kind = xsid_pkg::K_MOV_RR;
              w.rec.dst  = rm_full;
            end else begin
              w.rec.kind = xsid_pkg::K_MOV_MR;
            end
          end
          xsid_pkg::OP_LEA: begin
            w.rec.kind = xsid_pkg::K_LEA;
            w.rec.dst  = reg_full;
          end
          xsid_pkg::OP_TEST: begin
            w.rec.kind  = xsid_pkg::K_TEST_RR;
            w.rec.dst   = rm_full;
            w.rec.src   = reg_full;
            w.rec.flags = 1'b1;
          end
          default: begin
            // reg-reg ALU forms; anything else falls to compare
            if (st.opcode == xsid_pkg::OP_ADD) begin
              w.rec.kind = xsid_pkg::K_ADD_RR;
            end else if (st.opcode == xsid_pkg::OP_SUB) begin
              w.rec.kind = xsid_pkg::K_SUB_RR;
            end else if (st.opcode == xsid_pkg::OP_XOR) begin
              w.rec.kind = xsid_pkg::K_XOR_RR;
            end else begin
              w.rec.kind = xsid_pkg::K_CMP_RR;
            end
            w.rec.dst   = reg_full;
            w.rec.src   = rm_full;
            w.rec.flags = 1'b1;
          end
        endcase
      end
      xsid_pkg::PH_OPC2: begin
        w.count = cnt_inc;
        if (code_byte inside {[xsid_pkg::OP2_JCC32 : xsid_pkg::OP2_JCC32 + 8'd15]}) begin
          w.rec.kind = xsid_pkg::K_JCC;
          w.rec.cond = code_byte[3:0];
          imm_go     = 1'b1;
          imm_want   = 4'd4;
        end else begin
          case (code_byte)
            xsid_pkg::OP2_SYSCALL: begin
              w.rec.kind = xsid_pkg::K_SYSCALL;
              emit       = 1'b1;
            end
            xsid_pkg::OP2_MOVAPS, xsid_pkg::OP2_MOVUPS,
            xsid_pkg::OP2_ADDPS, xsid_pkg::OP2_MULPS: begin
              if (code_byte == xsid_pkg::OP2_MOVAPS) begin
                w.rec.kind = xsid_pkg::K_MOVAPS;
              end else if (code_byte == xsid_pkg::OP2_MOVUPS) begin
                w.rec.kind = xsid_pkg::K_MOVUPS;
              end else if (code_byte == xsid_pkg::OP2_ADDPS) begin
                w.rec.kind = xsid_pkg::K_ADDPS;
              end else begin
                w.rec.kind = xsid_pkg::K_MULPS;
              end
              // SSE ModRM byte is skipped unless code ends here
              if (end_of_code) begin
                emit = 1'b1;
              end else begin
                w.phase = xsid_pkg::PH_SSESKIP;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      xsid_pkg::PH_SSESKIP: begin
        w.count = cnt_inc;
        emit    = 1'b1;
      end
      xsid_pkg::PH_IMM: begin
        w.acc = acc_w;
        w.got = got_n;
        if (got_n >= st.want) begin
          emit  = 1'b1;
          imm   = xsid_pkg::sext_imm(acc_w, st.want);
          extra = st.want;
        end else if (end_of_code) begin
          emit = 1'b1;
          // short REX.W mov keeps its first four bytes as imm32
          if (st.want == 4'd8 && got_n >= 4'd4) begin
            imm   = xsid_pkg::sext_imm(acc_w, 4'd4);
            extra = 4'd4;
          end
        end
      end
      default: begin
        // prefix phase
        if (code_byte inside {xsid_pkg::PFX_LOCK, xsid_pkg::PFX_REPNE, xsid_pkg::PFX_REP,
                              xsid_pkg::PFX_OPSZ, xsid_pkg::PFX_ADSZ, xsid_pkg::PFX_CS,
                              xsid_pkg::PFX_DS, xsid_pkg::PFX_ES, xsid_pkg::PFX_FS,
                              xsid_pkg::PFX_GS, xsid_pkg::PFX_SS}) begin
          if (code_byte == xsid_pkg::PFX_LOCK) begin
            w.pfx[0] = 1'b1;
          end
          if (code_byte == xsid_pkg::PFX_REPNE || code_byte == xsid_pkg::PFX_REP) begin
            w.pfx[1] = 1'b1;
          end
          w.count = cnt_inc;
          if (end_of_code) begin
            emit = 1'b1;
            ok   = 1'b0;
          end
        end else if (code_byte[7:4] == xsid_pkg::REX_HI) begin
          w.rex   = code_byte[3:0];
          w.count = cnt_inc;
          if (end_of_code) begin
            emit = 1'b1;
            ok   = 1'b0;
          end else begin
            w.phase = xsid_pkg::PH_OPCODE;
          end
        end else begin
          opc_go = 1'b1;
        end
      end
    endcase

    // Primary opcode byte
    if (opc_go) begin
      w.count  = cnt_inc;
      w.opcode = code_byte;
      if (code_byte inside {[xsid_pkg::OP_PUSH : xsid_pkg::OP_PUSH + 8'd7]}) begin
        w.rec.kind = xsid_pkg::K_PUSH;
        w.rec.src  = {1'b0, w.rex[0], code_byte[2:0]};
        emit       = 1'b1;
      end else if (code_byte inside {[xsid_pkg::OP_POP : xsid_pkg::OP_POP + 8'd7]}) begin
        w.rec.kind = xsid_pkg::K_POP;
        w.rec.dst  = {1'b0, w.rex[0], code_byte[2:0]};
        emit       = 1'b1;
      end else if (code_byte inside {[xsid_pkg::OP_MOV_IMM : xsid_pkg::OP_MOV_IMM + 8'd7]}) begin
        w.rec.kind = xsid_pkg::K_MOV_RI;
        w.rec.dst  = {1'b0, w.rex[0], code_byte[2:0]};
        imm_go     = 1'b1;
        imm_want   = w.rex[3] ? 4'd8 : 4'd4;
      end else if (code_byte inside {[xsid_pkg::OP_JCC8 : xsid_pkg::OP_JCC8 + 8'd15]}) begin
        w.rec.kind = xsid_pkg::K_JCC;
        w.rec.cond = code_byte[3:0];
        imm_go     = 1'b1;
        imm_want   = 4'd1;
      end else begin
        case (code_byte)
          xsid_pkg::OP_NOP: begin
            w.rec.kind = xsid_pkg::K_NOP;
            emit       = 1'b1;
          end
          xsid_pkg::OP_RET: begin
            w.rec.kind = xsid_pkg::K_RET;
            emit       = 1'b1;
          end
          xsid_pkg::OP_INT3: begin
            w.rec.kind = xsid_pkg::K_INT3;
            emit       = 1'b1;
          end
          xsid_pkg::OP_GRP83, xsid_pkg::OP_MOV_LOAD, xsid_pkg::OP_MOV_STORE,
          xsid_pkg::OP_ADD, xsid_pkg::OP_SUB, xsid_pkg::OP_XOR, xsid_pkg::OP_CMP,
          xsid_pkg::OP_TEST, xsid_pkg::OP_LEA: begin
            if (end_of_code) begin
              emit = 1'b1;
              ok   = 1'b0;
            end else begin
              w.phase = xsid_pkg::PH_MODRM;
            end
          end
          xsid_pkg::OP_JMP8: begin
            w.rec.kind = xsid_pkg::K_JMP_REL;
            imm_go     = 1'b1;
            imm_want   = 4'd1;
          end
          xsid_pkg::OP_JMP32: begin
            w.rec.kind = xsid_pkg::K_JMP_REL;
            imm_go     = 1'b1;
            imm_want   = 4'd4;
          end
          xsid_pkg::OP_CALL: begin
            w.rec.kind = xsid_pkg::K_CALL_REL;
            imm_go     = 1'b1;
            imm_want   = 4'd4;
          end
          xsid_pkg::OP_ESC: begin
            if (end_of_code) begin
              emit = 1'b1;
              ok   = 1'b0;
            end else begin
              w.phase = xsid_pkg::PH_OPC2;
            end
          end
          default: begin
            emit = 1'b1;
          end
        endcase
      end
    end

    // Immediate start; code ending here gives an empty immediate
    if (imm_go) begin
      if (end_of_code) begin
        emit = 1'b1;
      end else begin
        w.want  = imm_want;
        w.got   = 4'd0;
        w.acc   = 64'd0;
        w.phase = xsid_pkg::PH_IMM;
      end
    end
  end

  // Length with immediate bytes added, saturating
  assign len_sum = {1'b0, w.count} + {5'd0, extra};
  assign len_sat = len_sum[8] ? 8'hFF : len_sum[7:0];

  // Record; a failed decode reports only the prefixes
  always_comb begin
    res.emit  = emit;
    res.ok    = ok;
    res.kind  = ok ? w.rec.kind : xsid_pkg::K_UNKNOWN;
    res.dst   = ok ? w.rec.dst : xsid_pkg::REG_NONE;
    res.src   = ok ? w.rec.src : xsid_pkg::REG_NONE;
    res.cond  = ok ? w.rec.cond : 4'd0;
    res.imm   = ok ? imm : 64'd0;
    res.lock  = w.pfx[0];
    res.rep   = w.pfx[1];
    res.wide  = w.rex[3];
    res.flags = ok ? w.rec.flags : 1'b0;
    res.len   = ok ? len_sat : 8'd0;
  end

  assign st_nxt = emit ? xsid_pkg::st_clear() : w;

endmodule

// File: design/x86_subset_instruction_decoder.sv
`timescale 1ns / 1ps
// Top level of the streaming x86 subset decoder: input register, parse state, record register.
// Depends on xsid_pkg and xsid_step.

// Takes one code byte per request and can accept a new byte every cycle unless in_stall
// is high. Each byte is registered, parsed combinationally against the current parse
// state, and any completed instruction record is loaded into the output register. The
// output register is the only point of backpressure: a byte that completes an instruction
// waits in the input register while an older record is still stalled; bytes that only
// advance the parse keep flowing.

module x86_subset_instruction_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_code_byte,
  input  logic               in_end_of_code,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_decoded_ok,
  output logic [5:0]         out_instr_kind,
  output logic [4:0]         out_dest_register,
  output logic [4:0]         out_source_register,
  output logic [3:0]         out_branch_condition,
  output logic signed [63:0] out_immediate_value,
  output logic               out_lock_seen,
  output logic               out_rep_seen,
  output logic               out_wide_operand,
  output logic               out_sets_flags,
  output logic [7:0]         out_instr_length
);

  logic           in_vld_r;
  logic [7:0]     in_byte_r;
  logic           in_end_r;
  xsid_pkg::st_t  st_r;
  xsid_pkg::st_t  st_nxt;
  xsid_pkg::res_t step_res;
  logic           out_vld_r;
  xsid_pkg::res_t out_res_r;
  logic           consume;

  // Parse step
  xsid_step u_step (
    .st          (st_r),
    .code_byte   (in_byte_r),
    .end_of_code (in_end_r),
    .st_nxt      (st_nxt),
    .res         (step_res)
  );

  // Byte retires unless its record has nowhere to go
  assign consume  = in_vld_r && (!step_res.emit || !out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !consume;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_code_byte;
      in_end_r  <= in_end_of_code;
    end
  end

  // Parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= xsid_pkg::st_clear();
    end else if (consume) begin
      st_r <= st_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (consume && step_res.emit) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && step_res.emit) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_decoded_ok       = out_res_r.ok;
  assign out_instr_kind       = out_res_r.kind;
  assign out_dest_register    = out_res_r.dst;
  assign out_source_register  = out_res_r.src;
  assign out_branch_condition = out_res_r.cond;
  assign out_immediate_value  = out_res_r.imm;
  assign out_lock_seen        = out_res_r.lock;
  assign out_rep_seen         = out_res_r.rep;
  assign out_wide_operand     = out_res_r.wide;
  assign out_sets_flags       = out_res_r.flags;
  assign out_instr_length     = out_res_r.len;

endmodule

// File: design/xsid_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the x86 subset decoder, bound to the top level.
// Depends on xsid_pkg.

module xsid_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_decoded_ok,
  input logic [5:0]         out_instr_kind,
  input logic [3:0]         out_branch_condition,
  input logic signed [63:0] out_immediate_value,
  input logic [7:0]         out_instr_length
);

  // No record right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("record valid after reset");

  // Stalled record holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_instr_kind)
      && $stable(out_immediate_value) && $stable(out_instr_length))
    else $error("stalled record changed");

  // Failed decode carries no operation, immediate or length
  a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_decoded_ok |-> out_instr_length == 8'd0
      && out_instr_kind == xsid_pkg::K_UNKNOWN && out_immediate_value == 64'sd0)
    else $error("failed decode has payload");

  // Decoded instruction consumed at least one byte
  a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_decoded_ok |-> out_instr_length != 8'd0)
    else $error("decoded instruction with zero length");

  // Condition nibble only on conditional jumps
  a_cond_jcc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_branch_condition != 4'd0 |-> out_instr_kind == xsid_pkg::K_JCC)
    else $error("condition on non-jcc record");

endmodule

bind x86_subset_instruction_decoder xsid_checker u_xsid_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_decoded_ok       (out_decoded_ok),
  .out_instr_kind       (out_instr_kind),
  .out_branch_condition (out_branch_condition),
  .out_immediate_value  (out_immediate_value),
  .out_instr_length     (out_instr_length)
);

// File: test/decode_check_pkg.sv
`timescale 1ns / 1ps
// Record type and scoreboard class for the x86 subset decoder testbench.
// Depends on xsid_pkg for opcode, phase and kind codes.

package decode_check_pkg;

  import xsid_pkg::*;

  // One decoded instruction record as seen on the result port
  typedef struct {
    logic        ok;
    logic [5:0]  kind;
    logic [4:0]  dst;
    logic [4:0]  src;
    logic [3:0]  cond;
    logic [63:0] imm;
    logic        lock;
    logic        rep;
    logic        wide;
    logic        flags;
    logic [7:0]  len;
  } decoded_t;

  // Tracks the parse of the byte stream and holds the records still due
  class decode_scoreboard;
    logic [2:0]  step_phase;
    logic [7:0]  byte_count;
    logic [3:0]  rex_nib;      // W,R,X,B
    logic        lock_flag;
    logic        rep_flag;
    logic [7:0]  held_opcode;
    logic [5:0]  rec_kind;
    logic [4:0]  rec_dst;
    logic [4:0]  rec_src;
    logic [3:0]  rec_cond;
    logic        rec_flags;
    logic [63:0] imm_acc;
    int          imm_have;
    int          imm_need;
    decoded_t    expected_records[$];
    int          mismatches;
    int          records_checked;
    int          early_ends;

    function new();
      start_instruction();
      mismatches = 0;
      records_checked = 0;
      early_ends = 0;
    endfunction

    function void start_instruction();
      step_phase  = PH_PREFIX;
      byte_count  = 8'd0;
      rex_nib     = 4'd0;
      lock_flag   = 1'b0;
      rep_flag    = 1'b0;
      held_opcode = 8'd0;
      rec_kind    = K_UNKNOWN;
      rec_dst     = REG_NONE;
      rec_src     = REG_NONE;
      rec_cond    = 4'd0;
      rec_flags   = 1'b0;
      imm_acc     = 64'd0;
      imm_have    = 0;
      imm_need    = 0;
    endfunction

    function void count_byte();
      if (byte_count != 8'd255) byte_count++;
    endfunction

    function logic [63:0] sign_widen(logic [63:0] v, int nbytes);
      if (nbytes == 1) return {{56{v[7]}}, v[7:0]};
      if (nbytes == 4) return {{32{v[31]}}, v[31:0]};
      return v;
    endfunction

    // Queue the finished record and begin a fresh instruction
    function void close_record(logic ok, logic [63:0] imm, int extra);
      decoded_t d;
      int total;
      total = byte_count + extra;
      if (total > 255) total = 255;
      d.ok    = ok;
      d.kind  = ok ? rec_kind : K_UNKNOWN;
      d.dst   = ok ? rec_dst : REG_NONE;
      d.src   = ok ? rec_src : REG_NONE;
      d.cond  = ok ? rec_cond : 4'd0;
      d.imm   = ok ? imm : 64'd0;
      d.lock  = lock_flag;
      d.rep   = rep_flag;
      d.wide  = rex_nib[3];
      d.flags = ok ? rec_flags : 1'b0;
      d.len   = ok ? 8'(total) : 8'd0;
      if (!ok) early_ends++;
      expected_records.push_back(d);
      start_instruction();
    endfunction

    function void open_immediate(int nbytes, logic eoc);
      if (eoc) begin
        close_record(1'b1, 64'd0, 0);
      end else begin
        imm_need   = nbytes;
        imm_have   = 0;
        imm_acc    = 64'd0;
        step_phase = PH_IMM;
      end
    endfunction

    function logic is_legacy_prefix(logic [7:0] b);
      case (b)
        PFX_LOCK, PFX_REPNE, PFX_REP, PFX_OPSZ, PFX_ADSZ, PFX_CS, PFX_DS,
        PFX_ES, PFX_FS, PFX_GS, PFX_SS: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function void take_opcode(logic [7:0] b, logic eoc);
      logic [4:0] low_reg;
      low_reg = {1'b0, rex_nib[0], b[2:0]};
      count_byte();
      held_opcode = b;
      if (b[7:3] == OP_PUSH[7:3]) begin
        rec_kind = K_PUSH;
        rec_src  = low_reg;
        close_record(1'b1, 64'd0, 0);
      end else if (b[7:3] == OP_POP[7:3]) begin
        rec_kind = K_POP;
        rec_dst  = low_reg;
        close_record(1'b1, 64'd0, 0);
      end else if (b[7:3] == OP_MOV_IMM[7:3]) begin
        rec_kind = K_MOV_RI;
        rec_dst  = low_reg;
        open_immediate(rex_nib[3] ? 8 : 4, eoc);
      end else if (b[7:4] == OP_JCC8[7:4]) begin
        rec_kind = K_JCC;
        rec_cond = b[3:0];
        open_immediate(1, eoc);
      end else begin
        case (b)
          OP_NOP: begin
            rec_kind = K_NOP;
            close_record(1'b1, 64'd0, 0);
          end
          OP_RET: begin
            rec_kind = K_RET;
            close_record(1'b1, 64'd0, 0);
          end
          OP_INT3: begin
            rec_kind = K_INT3;
            close_record(1'b1, 64'd0, 0);
          end
          OP_GRP83, OP_MOV_LOAD, OP_MOV_STORE, OP_ADD, OP_SUB, OP_XOR, OP_CMP,
          OP_TEST, OP_LEA: begin
            if (eoc) close_record(1'b0, 64'd0, 0);
            else step_phase = PH_MODRM;
          end
          OP_JMP8: begin
            rec_kind = K_JMP_REL;
            open_immediate(1, eoc);
          end
          OP_JMP32: begin
            rec_kind = K_JMP_REL;
            open_immediate(4, eoc);
          end
          OP_CALL: begin
            rec_kind = K_CALL_REL;
            open_immediate(4, eoc);
          end
          OP_ESC: begin
            if (eoc) close_record(1'b0, 64'd0, 0);
            else step_phase = PH_OPC2;
          end
          default: close_record(1'b1, 64'd0, 0);
        endcase
      end
    endfunction

    function void take_modrm(logic [7:0] m, logic eoc);
      logic [4:0] reg_full;
      logic [4:0] rm_full;
      reg_full = {1'b0, rex_nib[2], m[5:3]};
      rm_full  = {1'b0, rex_nib[0], m[2:0]};
      count_byte();
      case (held_opcode)
        OP_GRP83: begin
          // operation from the 3-bit reg field, REX.R ignored
          rec_flags = 1'b1;
          case (m[5:3])
            3'd0:    rec_kind = K_ADD_RI;
            3'd1:    rec_kind = K_OR_RI;
            3'd4:    rec_kind = K_AND_RI;
            3'd5:    rec_kind = K_SUB_RI;
            3'd6:    rec_kind = K_XOR_RI;
            3'd7:    rec_kind = K_CMP_RI;
            default: rec_kind = K_UNKNOWN;
          endcase
          if (m[7:6] == 2'b11) rec_dst = rm_full;
          open_immediate(1, eoc);
          return;
        end
        OP_MOV_LOAD: begin
          rec_dst = reg_full;
          if (m[7:6] == 2'b11) begin
            rec_kind = K_MOV_RR;
            rec_src  = rm_full;
          end else begin
            rec_kind = K_MOV_RM;
          end
        end
        OP_MOV_STORE: begin
          rec_src = reg_full;
          if (m[7:6] == 2'b11) begin
            rec_kind = K_MOV_RR;
            rec_dst  = rm_full;
          end else begin
            rec_kind = K_MOV_MR;
          end
        end
        OP_LEA: begin
          rec_kind = K_LEA;
          rec_dst  = reg_full;
        end
        OP_TEST: begin
          rec_kind  = K_TEST_RR;
          rec_dst   = rm_full;
          rec_src   = reg_full;
          rec_flags = 1'b1;
        end
        default: begin
          case (held_opcode)
            OP_ADD:  rec_kind = K_ADD_RR;
            OP_SUB:  rec_kind = K_SUB_RR;
            OP_XOR:  rec_kind = K_XOR_RR;
            default: rec_kind = K_CMP_RR;
          endcase
          rec_dst   = reg_full;
          rec_src   = rm_full;
          rec_flags = 1'b1;
        end
      endcase
      close_record(1'b1, 64'd0, 0);
    endfunction

    function void take_escape(logic [7:0] b, logic eoc);
      count_byte();
      if (b[7:4] == OP2_JCC32[7:4]) begin
        rec_kind = K_JCC;
        rec_cond = b[3:0];
        open_immediate(4, eoc);
        return;
      end
      case (b)
        OP2_SYSCALL: begin
          rec_kind = K_SYSCALL;
          close_record(1'b1, 64'd0, 0);
          return;
        end
        OP2_MOVAPS: rec_kind = K_MOVAPS;
        OP2_MOVUPS: rec_kind = K_MOVUPS;
        OP2_ADDPS:  rec_kind = K_ADDPS;
        OP2_MULPS:  rec_kind = K_MULPS;
        default: begin
          close_record(1'b1, 64'd0, 0);
          return;
        end
      endcase
      // SSE op: its ModRM byte is skipped, or dropped when code ends here
      if (eoc) close_record(1'b1, 64'd0, 0);
      else step_phase = PH_SSESKIP;
    endfunction

    function void take_imm_byte(logic [7:0] b, logic eoc);
      imm_acc  = imm_acc | (64'(b) << (8 * (imm_have & 7)));
      imm_have = (imm_have & 7) + 1;
      if (imm_have >= imm_need) begin
        close_record(1'b1, sign_widen(imm_acc, imm_need), imm_need);
      end else if (eoc) begin
        // a cut-short imm64 with 4 bytes in hand falls back to imm32
        if (imm_need == 8 && imm_have >= 4)
          close_record(1'b1, sign_widen(imm_acc, 4), 4);
        else
          close_record(1'b1, 64'd0, 0);
      end
    endfunction

    // Advance the parse by one accepted code byte
    function void note_request(logic [7:0] b, logic eoc);
      case (step_phase)
        PH_OPCODE:  take_opcode(b, eoc);
        PH_MODRM:   take_modrm(b, eoc);
        PH_OPC2:    take_escape(b, eoc);
        PH_SSESKIP: begin
          count_byte();
          close_record(1'b1, 64'd0, 0);
        end
        PH_IMM:     take_imm_byte(b, eoc);
        default: begin
          if (is_legacy_prefix(b)) begin
            if (b == PFX_LOCK) lock_flag = 1'b1;
            if (b == PFX_REPNE || b == PFX_REP) rep_flag = 1'b1;
            count_byte();
            if (eoc) close_record(1'b0, 64'd0, 0);
          end else if (b[7:4] == REX_HI) begin
            rex_nib = b[3:0];
            count_byte();
            if (eoc) close_record(1'b0, 64'd0, 0);
            else step_phase = PH_OPCODE;
          end else begin
            take_opcode(b, eoc);
          end
        end
      endcase
    endfunction

    function void compare_field(string name, logic [63:0] want_v, logic [63:0] seen_v);
      if (seen_v !== want_v) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want_v, seen_v);
        mismatches++;
      end
    endfunction

    function void check_record(decoded_t seen);
      decoded_t want;
      if (expected_records.size() == 0) begin
        $error("record with no instruction pending: kind %0d len %0d", seen.kind, seen.len);
        mismatches++;
        return;
      end
      want = expected_records.pop_front();
      records_checked++;
      compare_field("decoded_ok", want.ok, seen.ok);
      compare_field("instr_kind", want.kind, seen.kind);
      compare_field("dest_register", want.dst, seen.dst);
      compare_field("source_register", want.src, seen.src);
      compare_field("branch_condition", want.cond, seen.cond);
      compare_field("immediate_value", want.imm, seen.imm);
      compare_field("lock_seen", want.lock, seen.lock);
      compare_field("rep_seen", want.rep, seen.rep);
      compare_field("wide_operand", want.wide, seen.wide);
      compare_field("sets_flags", want.flags, seen.flags);
      compare_field("instr_length", want.len, seen.len);
    endfunction
  endclass

endpackage

// File: test/testbench.sv
`timescale 1ns / 1ps
// Top testbench for the streaming x86 subset decoder: directed and random code streams.
// Depends on xsid_pkg, decode_check_pkg and the decoder RTL.

module testbench;

  import xsid_pkg::*;
  import decode_check_pkg::*;

  localparam int TOTAL_BYTES  = 1550;
  localparam int QUIET_TAIL   = 150;
  localparam int HOLD_AT      = 500;
  localparam int HOLD_CYCLES  = 300;
  localparam int STUCK_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 10;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_code_byte = 8'd0;
  logic        in_end_of_code = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_decoded_ok;
  logic [5:0]  out_instr_kind;
  logic [4:0]  out_dest_register;
  logic [4:0]  out_source_register;
  logic [3:0]  out_branch_condition;
  logic [63:0] out_immediate_value;
  logic        out_lock_seen;
  logic        out_rep_seen;
  logic        out_wide_operand;
  logic        out_sets_flags;
  logic [7:0]  out_instr_length;

  decode_scoreboard board = new();
  logic [7:0] instr_bytes[$];
  logic [7:0] legacy_prefixes[11] = '{PFX_LOCK, PFX_REPNE, PFX_REP, PFX_OPSZ, PFX_ADSZ,
                                      PFX_CS, PFX_DS, PFX_ES, PFX_FS, PFX_GS, PFX_SS};
  logic [7:0] modrm_opcodes[8] = '{OP_GRP83, OP_MOV_LOAD, OP_MOV_STORE, OP_ADD, OP_SUB,
                                   OP_XOR, OP_CMP, OP_TEST};
  int  bytes_sent = 0;
  int  stuck_cycles = 0;
  bit  quiet = 1'b0;
  bit  hold_done = 1'b0;

  x86_subset_instruction_decoder uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_code_byte         (in_code_byte),
    .in_end_of_code       (in_end_of_code),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_decoded_ok       (out_decoded_ok),
    .out_instr_kind       (out_instr_kind),
    .out_dest_register    (out_dest_register),
    .out_source_register  (out_source_register),
    .out_branch_condition (out_branch_condition),
    .out_immediate_value  (out_immediate_value),
    .out_lock_seen        (out_lock_seen),
    .out_rep_seen         (out_rep_seen),
    .out_wide_operand     (out_wide_operand),
    .out_sets_flags       (out_sets_flags),
    .out_instr_length     (out_instr_length)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Monitor: results are checked before the same-edge request is noted
  always @(posedge clk) begin
    decoded_t seen;
    logic moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        seen.ok    = out_decoded_ok;
        seen.kind  = out_instr_kind;
        seen.dst   = out_dest_register;
        seen.src   = out_source_register;
        seen.cond  = out_branch_condition;
        seen.imm   = out_immediate_value;
        seen.lock  = out_lock_seen;
        seen.rep   = out_rep_seen;
        seen.wide  = out_wide_operand;
        seen.flags = out_sets_flags;
        seen.len   = out_instr_length;
        board.check_record(seen);
        moved = 1'b1;
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        board.note_request(in_code_byte, in_end_of_code);
        moved = 1'b1;
      end
      stuck_cycles = moved ? 0 : stuck_cycles + 1;
    end
  end

  // Watchdog on cycles without any transfer
  initial begin
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side: stall bursts, calm stretches and one long hold-off
  initial begin : receiver
    int pick;
    @(posedge clk);
    forever begin
      pick = $urandom_range(0, 15);
      if (!hold_done && bytes_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && pick < 2) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else if (!quiet && pick == 2) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // One code byte request, with an occasional idle gap ahead of it
  task automatic send_byte(input logic [7:0] b, input logic eoc);
    if (!quiet && $urandom_range(0, 11) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_code_byte   <= b;
    in_end_of_code <= eoc;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    bytes_sent++;
    if (bytes_sent >= TOTAL_BYTES - QUIET_TAIL) quiet = 1'b1;
  endtask

  // Send instr_bytes; code ends on index cut (none when negative)
  task automatic send_instr(input int cut);
    for (int i = 0; i < instr_bytes.size(); i++) begin
      send_byte(instr_bytes[i], i == cut);
      if (i == cut) break;
    end
  endtask

  function automatic logic [7:0] data_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_data(input int n);
    repeat (n) instr_bytes.push_back(data_byte());
  endfunction

  function automatic logic [7:0] rand_modrm();
    logic [7:0] m;
    m = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 1) == 1) m[7:6] = 2'b11;
    return m;
  endfunction

  // Mostly well-formed instructions with random operands; some noise bytes
  function automatic void make_random_instr();
    logic [3:0] rex_low;
    logic       wide;
    wide = 1'b0;
    instr_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      instr_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) instr_bytes.push_back(legacy_prefixes[$urandom_range(0, 10)]);
    if ($urandom_range(0, 2) == 0) begin
      rex_low = 4'($urandom_range(0, 15));
      wide = rex_low[3];
      instr_bytes.push_back({REX_HI, rex_low});
    end
    case ($urandom_range(0, 9))
      0: instr_bytes.push_back(($urandom_range(0, 1) ? OP_PUSH : OP_POP) |
                               8'($urandom_range(0, 7)));
      1: begin
        instr_bytes.push_back(OP_MOV_IMM | 8'($urandom_range(0, 7)));
        add_data(wide ? 8 : 4);
      end
      2: begin
        instr_bytes.push_back(OP_JCC8 | 8'($urandom_range(0, 15)));
        add_data(1);
      end
      3: begin
        instr_bytes.push_back(OP_GRP83);
        instr_bytes.push_back(rand_modrm());
        add_data(1);
      end
      4: begin
        instr_bytes.push_back($urandom_range(0, 7) == 0 ? OP_LEA
                                                        : modrm_opcodes[$urandom_range(1, 7)]);
        instr_bytes.push_back(rand_modrm());
      end
      5: begin
        case ($urandom_range(0, 2))
          0: begin instr_bytes.push_back(OP_JMP8);  add_data(1); end
          1: begin instr_bytes.push_back(OP_JMP32); add_data(4); end
          default: begin instr_bytes.push_back(OP_CALL); add_data(4); end
        endcase
      end
      6: begin
        instr_bytes.push_back(OP_ESC);
        instr_bytes.push_back(OP2_JCC32 | 8'($urandom_range(0, 15)));
        add_data(4);
      end
      7: begin
        instr_bytes.push_back(OP_ESC);
        case ($urandom_range(0, 5))
          0: instr_bytes.push_back(OP2_SYSCALL);
          1: begin instr_bytes.push_back(OP2_MOVAPS); instr_bytes.push_back(rand_modrm()); end
          2: begin instr_bytes.push_back(OP2_MOVUPS); instr_bytes.push_back(rand_modrm()); end
          3: begin instr_bytes.push_back(OP2_ADDPS);  instr_bytes.push_back(rand_modrm()); end
          4: begin instr_bytes.push_back(OP2_MULPS);  instr_bytes.push_back(rand_modrm()); end
          default: instr_bytes.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      8: begin
        case ($urandom_range(0, 2))
          0:       instr_bytes.push_back(OP_NOP);
          1:       instr_bytes.push_back(OP_RET);
          default: instr_bytes.push_back(OP_INT3);
        endcase
      end
      default: begin
        instr_bytes.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 1) instr_bytes.push_back(8'($urandom_range(0, 255)));
      end
    endcase
  endfunction

  // Directed part: each operation, field extremes and the odd endings
  task automatic run_directed();
    instr_bytes = '{OP_NOP};                                   send_instr(-1);
    instr_bytes = '{PFX_REP, OP_RET};                          send_instr(-1);
    instr_bytes = '{PFX_LOCK, PFX_REPNE, PFX_CS, OP_INT3};     send_instr(-1);
    instr_bytes = '{{REX_HI, 4'h1}, OP_PUSH | 8'h07};          send_instr(-1);
    instr_bytes = '{OP_POP, OP_PUSH};                          send_instr(-1);
    // imm64 with the top bit set, then imm32 at its positive limit
    instr_bytes = '{{REX_HI, 4'h9}, OP_MOV_IMM | 8'h07, 8'h01, 8'h23, 8'h45, 8'h67,
                    8'h89, 8'hAB, 8'hCD, 8'h80};               send_instr(-1);
    instr_bytes = '{OP_MOV_IMM, 8'hFF, 8'hFF, 8'hFF, 8'h7F};   send_instr(-1);
    instr_bytes = '{OP_JCC8 | 8'h0F, 8'h80};                   send_instr(-1);
    // every group 0x83 operation, REX.R set to show it is ignored
    for (int r = 0; r < 8; r++) begin
      instr_bytes = '{{REX_HI, 4'h5}, OP_GRP83, 8'hC0 | 8'(r << 3), 8'hFF};
      send_instr(-1);
    end
    instr_bytes = '{OP_GRP83, 8'h38, 8'h05};                   send_instr(-1);
    // register and memory forms of the ModRM opcodes other than group 0x83
    for (int k = 1; k < 8; k++) begin
      instr_bytes = '{{REX_HI, 4'hD}, modrm_opcodes[k], 8'hC8, modrm_opcodes[k], 8'h00};
      send_instr(-1);
    end
    instr_bytes = '{OP_LEA, 8'h44, OP_JMP8, 8'hFE};            send_instr(-1);
    instr_bytes = '{OP_JMP32, 8'h00, 8'h00, 8'h00, 8'h80,
                    OP_CALL, 8'hFF, 8'hFF, 8'hFF, 8'hFF};      send_instr(-1);
    instr_bytes = '{OP_ESC, OP2_JCC32 | 8'h0F, 8'h10, 8'h20, 8'h30, 8'h40,
                    OP_ESC, OP2_SYSCALL, OP_ESC, 8'hFF};       send_instr(-1);
    instr_bytes = '{OP_ESC, OP2_MOVAPS, 8'hC1, OP_ESC, OP2_MOVUPS, 8'h00,
                    OP_ESC, OP2_ADDPS, 8'hFF, OP_ESC, OP2_MULPS, 8'h12};
    send_instr(-1);
    // code ending before the opcode, the second opcode byte or the ModRM byte
    instr_bytes = '{PFX_LOCK};                                 send_instr(0);
    instr_bytes = '{{REX_HI, 4'h8}};                           send_instr(0);
    instr_bytes = '{PFX_REP, OP_ESC};                          send_instr(1);
    instr_bytes = '{{REX_HI, 4'h8}, OP_GRP83};                 send_instr(1);
    // immediates cut short, including the imm32 fallback of a wide mov
    instr_bytes = '{OP_MOV_IMM, 8'h11, 8'h22};                 send_instr(2);
    instr_bytes = '{{REX_HI, 4'h8}, OP_MOV_IMM, 8'h01, 8'h02, 8'h03, 8'h84, 8'h05};
    send_instr(6);
    instr_bytes = '{{REX_HI, 4'h8}, OP_MOV_IMM, 8'h01, 8'h02, 8'h03};
    send_instr(4);
    instr_bytes = '{OP_JMP8};                                  send_instr(0);
    // SSE op ending on its second opcode byte
    instr_bytes = '{OP_ESC, OP2_MOVAPS};                       send_instr(1);
    // second REX and a late prefix are taken as unknown opcodes
    instr_bytes = '{{REX_HI, 4'h8}, {REX_HI, 4'h1}, OP_NOP};   send_instr(-1);
    instr_bytes = '{{REX_HI, 4'h0}, PFX_LOCK, OP_NOP};         send_instr(-1);
    // prefix run long enough to saturate the length
    instr_bytes.delete();
    repeat (260) instr_bytes.push_back(PFX_OPSZ);
    instr_bytes.push_back(PFX_LOCK);
    instr_bytes.push_back(OP_NOP);
    send_instr(-1);
  endtask

  initial begin
    int pick;
    int cut;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    while (bytes_sent < TOTAL_BYTES) begin
      make_random_instr();
      pick = $urandom_range(0, 99);
      if (pick < 12) cut = $urandom_range(0, instr_bytes.size() - 1);
      else if (pick < 17) cut = instr_bytes.size() - 1;
      else cut = -1;
      send_instr(cut);
    end
    in_valid <= 1'b0;
    while (board.expected_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d code bytes, %0d records checked (%0d ended early),",
             bytes_sent, board.records_checked, board.early_ends);
    $display("with stall bursts on both sides and one long result hold-off.");
    if (board.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
